// ===== rtl/free_space_max_tree_defines.svh =====
// assertion macros used by the checker file
`ifndef FREE_SPACE_MAX_TREE_DEFINES_SVH
`define FREE_SPACE_MAX_TREE_DEFINES_SVH

// property checked only while out of reset
`define FSMT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// property checked on every edge, reset included
`define FSMT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/fsmt_pkg.sv =====
// shared constants, types and index helpers for the free-space max tree
package fsmt_pkg;

    localparam int LEAF_COUNT = 1024;
    localparam int NODE_COUNT = 2 * LEAF_COUNT - 1;
    localparam int LEAF_BASE  = LEAF_COUNT - 1;
    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int SLOT_W     = 10;
    localparam int VAL_W      = 8;
    localparam int FUNC_W     = 2;

    typedef logic [NODE_W-1:0] t_node;
    typedef logic [VAL_W-1:0]  t_val;

    // operation codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_SET    = 2'd0,
        FUNC_SEARCH = 2'd1,
        FUNC_READ   = 2'd2,
        FUNC_CLEAR  = 2'd3
    } t_func;

    // left child in heap order: 2n+1
    function automatic t_node left_child(input t_node n);
        return {n[NODE_W-2:0], 1'b1};
    endfunction

    // parent in heap order: (n-1)/2, node 0 excluded
    function automatic t_node parent_of(input t_node n);
        t_node m;
        m = n - t_node'(1);
        return m >> 1;
    endfunction

    // other child of the same parent
    function automatic t_node sibling_of(input t_node n);
        return n[0] ? n + t_node'(1) : n - t_node'(1);
    endfunction

endpackage

// ===== rtl/fsmt_ram.sv =====
// generic ram: one write port, two registered read ports
module fsmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_b,
    output logic [WIDTH-1:0]         o_rd_data_a,
    output logic [WIDTH-1:0]         o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered reads
    always_ff @(posedge i_clk) begin
        o_rd_data_a <= r_mem[i_rd_addr_a];
        o_rd_data_b <= r_mem[i_rd_addr_b];
    end

endmodule

// ===== rtl/free_space_max_tree.sv =====
// free-space max tree: tree kept in one ram, walked one level per cycle
//
//  channel   ports                                            handshake
//  command   i_func i_slot_index i_new_value i_min_value      start, busy
//  result    o_found o_found_slot o_slot_value o_root_max     o_valid (one cycle)
//
// a set climbs from its leaf to the root and a search descends from the root to a
// leaf; a set or a read of a slot past the leaves and a search whose minimum is
// above the root give their result in the cycle after start; a clear sweeps the ram.
// at each tree level a set reads and writes the ram and a search reads it twice.
// after reset the ram is swept to zero with busy high.
// the result strobe lasts one cycle; a new item may be started in that cycle.
module free_space_max_tree
    import fsmt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [FUNC_W-1:0] i_func,
    input  logic [SLOT_W-1:0] i_slot_index,
    input  logic [VAL_W-1:0]  i_new_value,
    input  logic [VAL_W-1:0]  i_min_value,
    output logic              o_valid,
    output logic              o_found,
    output logic [SLOT_W-1:0] o_found_slot,
    output logic [VAL_W-1:0]  o_slot_value,
    output logic [VAL_W-1:0]  o_root_max
);

    typedef enum logic [4:0] {
        S_CLR  = 5'b00001,
        S_IDLE = 5'b00010,
        S_SET  = 5'b00100,
        S_SRCH = 5'b01000,
        S_READ = 5'b10000
    } t_state;

    t_state r_state, n_state;
    t_node  r_node, n_node;
    t_node  r_clr_addr, n_clr_addr;
    logic   r_clr_report, n_clr_report;
    t_val   r_cur, n_cur;
    t_val   r_min, n_min;
    t_val   r_root, n_root;
    logic   r_valid, n_valid;
    logic   r_found, n_found;
    logic [SLOT_W-1:0] r_fslot, n_fslot;
    t_val   r_sval, n_sval;

    logic  wr_en;
    t_node wr_addr;
    t_val  wr_data;
    t_node rd_addr_a, rd_addr_b;
    t_val  rd_data_a, rd_data_b;

    logic  slot_ok;
    t_node leaf_node;
    t_val  up_val;
    t_node up_parent;
    t_node dn_left;
    t_node dn_next;
    t_node dn_off;

    fsmt_ram #(
        .WIDTH (VAL_W),
        .DEPTH (NODE_COUNT)
    ) u_ram (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (rd_addr_b),
        .o_rd_data_a (rd_data_a),
        .o_rd_data_b (rd_data_b)
    );

    // slot decode
    assign slot_ok   = 32'(i_slot_index) < 32'(LEAF_COUNT);
    assign leaf_node = t_node'(LEAF_BASE) + t_node'(i_slot_index);

    // upward step: parent is the larger of the node just written and its sibling
    assign up_val    = (r_cur >= rd_data_a) ? r_cur : rd_data_a;
    assign up_parent = parent_of(r_node);

    // downward step: children of r_node are on ports a and b
    assign dn_left = left_child(r_node);
    assign dn_next = (rd_data_a >= r_min && rd_data_a >= rd_data_b) ? dn_left
                                                                    : dn_left + t_node'(1);
    assign dn_off  = dn_next - t_node'(LEAF_BASE);

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_node       = r_node;
        n_clr_addr   = r_clr_addr;
        n_clr_report = r_clr_report;
        n_cur        = r_cur;
        n_min        = r_min;
        n_root       = r_root;
        n_valid      = 1'b0;
        n_found      = r_found;
        n_fslot      = r_fslot;
        n_sval       = r_sval;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_data      = '0;
        rd_addr_a    = '0;
        rd_addr_b    = '0;

        case (r_state)
            S_CLR: begin
                wr_en      = 1'b1;
                wr_addr    = r_clr_addr;
                n_clr_addr = r_clr_addr + t_node'(1);
                if (r_clr_addr == t_node'(NODE_COUNT - 1)) begin
                    n_state = S_IDLE;
                    n_root  = '0;
                    if (r_clr_report) begin
                        n_valid = 1'b1;
                        n_found = 1'b0;
                        n_fslot = '0;
                        n_sval  = '0;
                    end
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_found = 1'b0;
                    n_fslot = '0;
                    n_sval  = '0;
                    case (t_func'(i_func))
                        FUNC_SET: begin
                            if (slot_ok) begin
                                wr_en     = 1'b1;
                                wr_addr   = leaf_node;
                                wr_data   = i_new_value;
                                rd_addr_a = sibling_of(leaf_node);
                                n_node    = leaf_node;
                                n_cur     = i_new_value;
                                n_state   = S_SET;
                            end else begin
                                n_valid = 1'b1;
                            end
                        end
                        FUNC_SEARCH: begin
                            n_min = i_min_value;
                            if (r_root < i_min_value) begin
                                n_valid = 1'b1;
                            end else begin
                                rd_addr_a = left_child('0);
                                rd_addr_b = left_child('0) + t_node'(1);
                                n_node    = '0;
                                n_state   = S_SRCH;
                            end
                        end
                        FUNC_READ: begin
                            if (slot_ok) begin
                                rd_addr_a = leaf_node;
                                n_state   = S_READ;
                            end else begin
                                n_valid = 1'b1;
                            end
                        end
                        FUNC_CLEAR: begin
                            n_clr_addr   = '0;
                            n_clr_report = 1'b1;
                            n_state      = S_CLR;
                        end
                        default: begin
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_SET: begin
                wr_en   = 1'b1;
                wr_addr = up_parent;
                wr_data = up_val;
                if (up_parent == '0) begin
                    n_root  = up_val;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    rd_addr_a = sibling_of(up_parent);
                    n_node    = up_parent;
                    n_cur     = up_val;
                end
            end
            S_SRCH: begin
                if (!(rd_data_a >= r_min && rd_data_a >= rd_data_b) && rd_data_b < r_min) begin
                    // neither child qualifies: not found
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else if (dn_next >= t_node'(LEAF_BASE)) begin
                    n_valid = 1'b1;
                    n_found = 1'b1;
                    n_fslot = SLOT_W'(dn_off);
                    n_state = S_IDLE;
                end else begin
                    rd_addr_a = left_child(dn_next);
                    rd_addr_b = left_child(dn_next) + t_node'(1);
                    n_node    = dn_next;
                end
            end
            S_READ: begin
                n_valid = 1'b1;
                n_sval  = rd_data_a;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLR;
            r_clr_addr   <= '0;
            r_clr_report <= 1'b0;
            r_root       <= '0;
            r_valid      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr_addr   <= n_clr_addr;
            r_clr_report <= n_clr_report;
            r_root       <= n_root;
            r_valid      <= n_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_node  <= n_node;
        r_cur   <= n_cur;
        r_min   <= n_min;
        r_found <= n_found;
        r_fslot <= n_fslot;
        r_sval  <= n_sval;
    end

    assign busy         = (r_state != S_IDLE);
    assign o_valid      = r_valid;
    assign o_found      = r_found;
    assign o_found_slot = r_fslot;
    assign o_slot_value = r_sval;
    assign o_root_max   = r_root;

endmodule

// ===== rtl/fsmt_checker.sv =====
// port-level checker for the free-space max tree, bound to the top level
`include "free_space_max_tree_defines.svh"

module fsmt_checker
    import fsmt_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_valid,
    input logic              o_found,
    input logic [SLOT_W-1:0] o_found_slot
);

    // reset always starts the clearing sweep
    `FSMT_ASSERT_ALWAYS(a_reset_sweeps, !i_rst_n |=> busy, "no sweep after reset")

    // a result is only shown when the block is free again
    `FSMT_ASSERT(a_valid_not_busy, o_valid |-> !busy, "result shown while busy")

    // an accepted item either starts work or answers at once
    `FSMT_ASSERT(a_accept_moves, (start && !busy) |=> (busy || o_valid), "item dropped")

    // no result without an item behind it
    `FSMT_ASSERT(a_valid_has_cause, o_valid |-> ($past(start) || $past(busy)),
                 "result without item")

    // a miss reports slot zero
    `FSMT_ASSERT(a_miss_slot_zero, (o_valid && !o_found) |-> (o_found_slot == '0),
                 "slot set on a miss")

endmodule

bind free_space_max_tree fsmt_checker u_fsmt_checker (.*);

// ===== sim/tb_top.sv =====
// testbench for the free-space max tree: directed table, then random operations
`timescale 1ns / 1ps

module tb_top
    import fsmt_pkg::*;
;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_ITEMS = 1400;
    localparam int DRAIN_CYCLES = 16;
    localparam int PRINT_CAP    = 50;

    // one result of the block, field by field
    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] found_slot;
        t_val              slot_value;
        t_val              root_max;
    } t_tree_result;

    // one row of the directed table; typed rows carry a hand-written result
    typedef struct packed {
        t_func             op;
        logic [SLOT_W-1:0] slot;
        t_val              new_val;
        t_val              min_val;
        logic              typed;
        t_tree_result      want;
    } t_cmd_row;

    localparam int DIRECTED_ROWS = 23;

    logic              i_clk;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [FUNC_W-1:0] i_func = '0;
    logic [SLOT_W-1:0] i_slot_index = '0;
    logic [VAL_W-1:0]  i_new_value = '0;
    logic [VAL_W-1:0]  i_min_value = '0;
    logic              o_valid;
    logic              o_found;
    logic [SLOT_W-1:0] o_found_slot;
    logic [VAL_W-1:0]  o_slot_value;
    logic [VAL_W-1:0]  o_root_max;

    // predictor state: heap-ordered copy of the tree and the search hint
    t_val              shadow_tree [0:NODE_COUNT-1];
    logic [SLOT_W-1:0] shadow_hint;

    t_tree_result pending_results [$];
    int           error_count = 0;
    int           results_seen = 0;
    int           cycle_count = 0;

    t_cmd_row directed_table [0:DIRECTED_ROWS-1] = '{
        '{FUNC_READ,   10'd0,    8'd0,   8'd0,   1'b1, '{1'b0, 10'd0,    8'd0,   8'd0}},
        '{FUNC_SEARCH, 10'd0,    8'd0,   8'd0,   1'b1, '{1'b1, 10'd0,    8'd0,   8'd0}},
        '{FUNC_SEARCH, 10'd0,    8'd0,   8'd1,   1'b1, '{1'b0, 10'd0,    8'd0,   8'd0}},
        '{FUNC_SET,    10'd1023, 8'd255, 8'd0,   1'b1, '{1'b0, 10'd0,    8'd0,   8'd255}},
        '{FUNC_SEARCH, 10'd0,    8'd0,   8'd255, 1'b1, '{1'b1, 10'd1023, 8'd0,   8'd255}},
        '{FUNC_READ,   10'd1023, 8'd0,   8'd0,   1'b1, '{1'b0, 10'd0,    8'd255, 8'd255}},
        '{FUNC_SET,    10'd0,    8'd255, 8'd0,   1'b1, '{1'b0, 10'd0,    8'd0,   8'd255}},
        '{FUNC_SEARCH, 10'd0,    8'd0,   8'd255, 1'b1, '{1'b1, 10'd0,    8'd0,   8'd255}},
        '{FUNC_SET,    10'd0,    8'd0,   8'd255, 1'b1, '{1'b0, 10'd0,    8'd0,   8'd255}},
        '{FUNC_SEARCH, 10'd1023, 8'd255, 8'd0,   1'b0, '0},
        '{FUNC_SET,    10'd512,  8'd128, 8'd0,   1'b0, '0},
        '{FUNC_SET,    10'd341,  8'd170, 8'd0,   1'b0, '0},
        '{FUNC_SET,    10'd682,  8'd85,  8'd0,   1'b0, '0},
        '{FUNC_SET,    10'd1023, 8'd1,   8'd0,   1'b0, '0},
        '{FUNC_SEARCH, 10'd0,    8'd0,   8'd129, 1'b0, '0},
        '{FUNC_SEARCH, 10'd0,    8'd0,   8'd171, 1'b0, '0},
        '{FUNC_READ,   10'd341,  8'd0,   8'd0,   1'b0, '0},
        '{FUNC_READ,   10'd682,  8'd0,   8'd0,   1'b0, '0},
        '{FUNC_SEARCH, 10'd0,    8'd0,   8'd0,   1'b0, '0},
        '{FUNC_CLEAR,  10'd1023, 8'd255, 8'd255, 1'b1, '{1'b0, 10'd0,    8'd0,   8'd0}},
        '{FUNC_READ,   10'd341,  8'd0,   8'd0,   1'b1, '{1'b0, 10'd0,    8'd0,   8'd0}},
        '{FUNC_SEARCH, 10'd0,    8'd0,   8'd0,   1'b1, '{1'b1, 10'd0,    8'd0,   8'd0}},
        '{FUNC_READ,   10'd1023, 8'd255, 8'd255, 1'b1, '{1'b0, 10'd0,    8'd0,   8'd0}}
    };

    free_space_max_tree u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_func       (i_func),
        .i_slot_index (i_slot_index),
        .i_new_value  (i_new_value),
        .i_min_value  (i_min_value),
        .o_valid      (o_valid),
        .o_found      (o_found),
        .o_found_slot (o_found_slot),
        .o_slot_value (o_slot_value),
        .o_root_max   (o_root_max)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // tree update and walk, applied to the shadow copy
    function automatic t_tree_result apply_tree_op(input t_func op, input logic [SLOT_W-1:0] slot,
                                                   input t_val new_val, input t_val min_val);
        t_tree_result res;
        int           node;
        int           lchild;
        bit           walking;
        res = '0;
        case (op)
            FUNC_SET: begin
                if (int'(slot) < LEAF_COUNT) begin
                    node = LEAF_BASE + int'(slot);
                    shadow_tree[node] = new_val;
                    // raise the path to the root
                    while (node != 0) begin
                        node = (node - 1) / 2;
                        lchild = 2 * node + 1;
                        shadow_tree[node] = (shadow_tree[lchild] >= shadow_tree[lchild+1]) ?
                                            shadow_tree[lchild] : shadow_tree[lchild+1];
                    end
                end
            end
            FUNC_SEARCH: begin
                if (shadow_tree[0] >= min_val) begin
                    node = 0;
                    walking = 1'b1;
                    // larger child first, left on a tie
                    while (walking && node < LEAF_BASE) begin
                        lchild = 2 * node + 1;
                        if (shadow_tree[lchild] >= min_val &&
                            shadow_tree[lchild] >= shadow_tree[lchild+1]) begin
                            node = lchild;
                        end else if (shadow_tree[lchild+1] >= min_val) begin
                            node = lchild + 1;
                        end else begin
                            walking = 1'b0;
                        end
                    end
                    if (walking) begin
                        res.found      = 1'b1;
                        res.found_slot = SLOT_W'(node - LEAF_BASE);
                        shadow_hint    = SLOT_W'(node - LEAF_BASE);
                    end
                end
            end
            FUNC_READ: begin
                if (int'(slot) < LEAF_COUNT)
                    res.slot_value = shadow_tree[LEAF_BASE + int'(slot)];
            end
            default: begin
                foreach (shadow_tree[i]) shadow_tree[i] = '0;
                shadow_hint = '0;
            end
        endcase
        res.root_max = shadow_tree[0];
        return res;
    endfunction

    // one line per mismatch, printing capped
    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        if (error_count <= PRINT_CAP)
            $display("mismatch on %s at result %0d: got %0d, expected %0d",
                     what, results_seen, got, want);
    endtask

    // drive one item after an idle gap, if any, wait for it to be taken, queue its result
    task automatic issue_item(input t_func op, input logic [SLOT_W-1:0] slot,
                              input t_val new_val, input t_val min_val, input int gap,
                              input logic typed, input t_tree_result want);
        t_tree_result predicted;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_func       <= op;
        i_slot_index <= slot;
        i_new_value  <= new_val;
        i_min_value  <= min_val;
        do @(posedge i_clk); while (busy);
        predicted = apply_tree_op(op, slot, new_val, min_val);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // hold the command side until every queued result has come back
    task automatic drain_results();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // stimulus
    initial begin
        int                n;
        int                pick;
        int                gap;
        bit                no_idle;
        t_func             op;
        logic [SLOT_W-1:0] slot;
        logic [SLOT_W-1:0] hot_base;
        t_val              new_val;
        t_val              min_val;

        foreach (shadow_tree[i]) shadow_tree[i] = '0;
        shadow_hint = '0;
        no_idle  = 1'b0;
        hot_base = '0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (n = 0; n < DIRECTED_ROWS; n++) begin
            issue_item(directed_table[n].op, directed_table[n].slot,
                       directed_table[n].new_val, directed_table[n].min_val,
                       $urandom_range(0, 5), directed_table[n].typed, directed_table[n].want);
        end

        // random operations, biased toward sets and searches over a hot region
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 64 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            if (n % 128 == 0)
                hot_base = SLOT_W'($urandom_range(0, LEAF_COUNT - 1));
            if (n == RANDOM_ITEMS / 2)
                drain_results();

            pick = $urandom_range(0, 99);
            if (pick < 1)
                op = FUNC_CLEAR;
            else if (pick < 42)
                op = FUNC_SET;
            else if (pick < 77)
                op = FUNC_SEARCH;
            else
                op = FUNC_READ;

            if ($urandom_range(0, 1) == 0)
                slot = {hot_base[SLOT_W-1:4], 4'($urandom_range(0, 15))};
            else
                slot = SLOT_W'($urandom_range(0, LEAF_COUNT - 1));

            case ($urandom_range(0, 7))
                0: new_val = '0;
                1: new_val = '1;
                default: new_val = t_val'($urandom_range(0, 255));
            endcase

            // search thresholds near the current root hit both outcomes
            case ($urandom_range(0, 5))
                0: min_val = '0;
                1: min_val = '1;
                2: min_val = shadow_tree[0];
                3: min_val = t_val'(shadow_tree[0] + 8'd1);
                default: min_val = t_val'($urandom_range(0, 255));
            endcase

            gap = no_idle ? 0 : $urandom_range(0, 5);
            issue_item(op, slot, new_val, min_val, gap, 1'b0, '0);
        end

        // wind down and report
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // result checker
    always @(posedge i_clk) begin
        t_tree_result want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_found !== want.found)
                    report_mismatch("found", o_found, want.found);
                if (o_found_slot !== want.found_slot)
                    report_mismatch("found_slot", o_found_slot, want.found_slot);
                if (o_slot_value !== want.slot_value)
                    report_mismatch("slot_value", o_slot_value, want.slot_value);
                if (o_root_max !== want.root_max)
                    report_mismatch("root_max", o_root_max, want.root_max);
            end
            results_seen++;
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/fsmt_pkg.sv
rtl/fsmt_ram.sv
rtl/free_space_max_tree.sv
rtl/fsmt_checker.sv
sim/tb_top.sv
